/* hdl/dpp_pkg.sv */
package dpp_pkg;

	// Field widths
	localparam int unsigned AngleW = 17;
	localparam int unsigned PosW   = 24;
	localparam int unsigned AerrW  = 18;
	localparam int unsigned SumW   = 48;
	localparam int unsigned GainW  = 16;
	localparam int unsigned CfgW   = 24;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned DriveW = 32;

	// Upright reference, 180.0 degrees in Q.8
	localparam logic signed [AerrW-1:0] RefAngle = 18'sd46080;

	// Register indexes
	localparam logic [IdxW-1:0] RegAngleP   = 3'd0;
	localparam logic [IdxW-1:0] RegAngleI   = 3'd1;
	localparam logic [IdxW-1:0] RegAngleD   = 3'd2;
	localparam logic [IdxW-1:0] RegPosP     = 3'd3;
	localparam logic [IdxW-1:0] RegPosI     = 3'd4;
	localparam logic [IdxW-1:0] RegPosD     = 3'd5;
	localparam logic [IdxW-1:0] RegStart    = 3'd6;
	localparam logic [IdxW-1:0] RegPreload  = 3'd7;

	// Register reset values
	localparam logic [GainW-1:0] AnglePReset = 16'd6400;
	localparam logic [GainW-1:0] AngleIReset = 16'd128;
	localparam logic [GainW-1:0] AngleDReset = 16'd1280;
	localparam logic [GainW-1:0] PosPReset   = 16'd64;
	localparam logic [GainW-1:0] PosIReset   = 16'd0;
	localparam logic [GainW-1:0] PosDReset   = 16'd38;
	localparam logic [GainW-1:0] StartReset  = 16'd44800;
	localparam logic signed [CfgW-1:0] PreloadReset = -24'sd1280000;

	// Drive saturation limits
	localparam logic [DriveW-1:0] DriveMax = 32'h7FFF_FFFF;
	localparam logic [DriveW-1:0] DriveMin = 32'h8000_0000;

	// Integral saturation limits
	localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
	localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

endpackage

/* hdl/dual_pid_pendulum_balance.sv */
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+------------------------------
// sample   | in        | sample_valid / sample_stall | pend_angle, cart_position
// drive    | out       | drive_valid / drive_stall   | drive
// config   | in        | cfg_we (no wait)            | cfg_index, cfg_data
//
// One sample per cycle sustained while drive_stall is low; a sample that engages or finds
// the controller engaged gives a drive through input, error, integrator, product, two add
// and output registers, a depth set by the split 16x48 integral products.
// Reset clears the engage latch, loop state and stage valids, loads register defaults.
// A stalled drive holds only the full stages behind it; empty stages keep
// filling, so samples keep transferring until the whole pipe is full.
module dual_pid_pendulum_balance (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [dpp_pkg::AngleW-1:0]     pend_angle,
	input  logic signed [dpp_pkg::PosW-1:0]       cart_position,
	output logic                                  drive_valid,
	input  logic                                  drive_stall,
	output logic signed [dpp_pkg::DriveW-1:0]     drive,
	input  logic                                  cfg_we,
	input  logic [dpp_pkg::IdxW-1:0]              cfg_index,
	input  logic [dpp_pkg::CfgW-1:0]              cfg_data
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [dpp_pkg::GainW-1:0]       angle_p_gain_q, angle_i_gain_q, angle_d_gain_q;
	logic [dpp_pkg::GainW-1:0]       pos_p_gain_q, pos_i_gain_q, pos_d_gain_q;
	logic [dpp_pkg::GainW-1:0]       start_angle_q;
	logic signed [dpp_pkg::CfgW-1:0] integral_preload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_p_gain_q     <= dpp_pkg::AnglePReset;
			angle_i_gain_q     <= dpp_pkg::AngleIReset;
			angle_d_gain_q     <= dpp_pkg::AngleDReset;
			pos_p_gain_q       <= dpp_pkg::PosPReset;
			pos_i_gain_q       <= dpp_pkg::PosIReset;
			pos_d_gain_q       <= dpp_pkg::PosDReset;
			start_angle_q      <= dpp_pkg::StartReset;
			integral_preload_q <= dpp_pkg::PreloadReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpp_pkg::RegAngleP:  angle_p_gain_q     <= cfg_data[dpp_pkg::GainW-1:0];
				dpp_pkg::RegAngleI:  angle_i_gain_q     <= cfg_data[dpp_pkg::GainW-1:0];
				dpp_pkg::RegAngleD:  angle_d_gain_q     <= cfg_data[dpp_pkg::GainW-1:0];
				dpp_pkg::RegPosP:    pos_p_gain_q       <= cfg_data[dpp_pkg::GainW-1:0];
				dpp_pkg::RegPosI:    pos_i_gain_q       <= cfg_data[dpp_pkg::GainW-1:0];
				dpp_pkg::RegPosD:    pos_d_gain_q       <= cfg_data[dpp_pkg::GainW-1:0];
				dpp_pkg::RegStart:   start_angle_q      <= cfg_data[dpp_pkg::GainW-1:0];
				dpp_pkg::RegPreload: integral_preload_q <= $signed(cfg_data);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stage flow control: a stage loads when it is empty or its
	// contents move on in the same cycle.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic free_s1, free_s2, free_s3, free_s4, free_s5, free_s6, free_s7;

	assign free_s7 = !v_s7 || !drive_stall;
	assign free_s6 = !v_s6 || free_s7;
	assign free_s5 = !v_s5 || free_s6;
	assign free_s4 = !v_s4 || free_s5;
	assign free_s3 = !v_s3 || free_s4;
	assign free_s2 = !v_s2 || free_s3;
	assign free_s1 = !v_s1 || free_s2;

	assign sample_stall = !free_s1;
	assign drive_valid  = v_s7;

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic signed [dpp_pkg::AngleW-1:0] ang_s1;
	logic signed [dpp_pkg::PosW-1:0]   pos_s1;

	always_ff @(posedge clk) begin
		if (sample_valid && free_s1) begin
			ang_s1 <= pend_angle;
			pos_s1 <= cart_position;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: errors and the engage threshold compare
	// ---------------------------------------------------------------
	logic [dpp_pkg::AerrW-1:0]          mag;
	logic signed [dpp_pkg::AerrW-1:0]   aerr_raw, aerr;
	logic signed [dpp_pkg::AerrW-1:0]   aerr_s2;
	logic signed [dpp_pkg::PosW-1:0]    perr_s2;
	logic                               reach_s2;

	always_comb begin
		// magnitude of a 17-bit angle needs 18 bits (most negative code)
		mag      = ang_s1[dpp_pkg::AngleW-1] ? 18'(-$signed(18'(ang_s1)))
		                                     : 18'(ang_s1);
		aerr_raw = dpp_pkg::RefAngle - $signed(mag);
		// flip the error for a positive angle
		aerr     = (!ang_s1[dpp_pkg::AngleW-1] && (ang_s1 != '0)) ? -aerr_raw : aerr_raw;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && free_s2) begin
			aerr_s2  <= aerr;
			perr_s2  <= pos_s1;
			reach_s2 <= (mag >= {2'b00, start_angle_q});
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: controller state (engage latch, integrals, prev errors)
	// ---------------------------------------------------------------
	logic                               engaged_q;
	logic signed [dpp_pkg::SumW-1:0]    angle_err_sum_q, pos_err_sum_q;
	logic signed [dpp_pkg::AerrW-1:0]   prev_angle_err_q;
	logic signed [dpp_pkg::PosW-1:0]    prev_pos_err_q;

	logic                               step;
	logic                               engage_now;
	logic signed [dpp_pkg::SumW-1:0]    asum_base, psum_base, asum_next, psum_next;
	logic signed [dpp_pkg::SumW:0]      asum_wide, psum_wide;

	assign step       = v_s2 && free_s3;
	assign engage_now = engaged_q || reach_s2;

	always_comb begin
		// preload on the engage sample, before it is accumulated
		asum_base = engaged_q ? angle_err_sum_q : 48'(integral_preload_q);
		psum_base = engaged_q ? pos_err_sum_q   : '0;
		asum_wide = 49'(asum_base) + 49'(aerr_s2);
		psum_wide = 49'(psum_base) + 49'(perr_s2);
		// saturate at the 48-bit limits on overflow
		if (asum_wide[dpp_pkg::SumW] != asum_wide[dpp_pkg::SumW-1]) begin
			asum_next = asum_wide[dpp_pkg::SumW] ? dpp_pkg::SumMin : dpp_pkg::SumMax;
		end else begin
			asum_next = asum_wide[dpp_pkg::SumW-1:0];
		end
		if (psum_wide[dpp_pkg::SumW] != psum_wide[dpp_pkg::SumW-1]) begin
			psum_next = psum_wide[dpp_pkg::SumW] ? dpp_pkg::SumMin : dpp_pkg::SumMax;
		end else begin
			psum_next = psum_wide[dpp_pkg::SumW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engaged_q        <= 1'b0;
			angle_err_sum_q  <= '0;
			pos_err_sum_q    <= '0;
			prev_angle_err_q <= '0;
			prev_pos_err_q   <= '0;
		end else if (step) begin
			engaged_q        <= engage_now;
			prev_angle_err_q <= aerr_s2;
			prev_pos_err_q   <= perr_s2;
			if (engage_now) begin
				angle_err_sum_q <= asum_next;
				pos_err_sum_q   <= psum_next;
			end
		end
	end

	logic signed [dpp_pkg::AerrW-1:0]  aerr_s3;
	logic signed [dpp_pkg::PosW-1:0]   perr_s3;
	logic signed [dpp_pkg::SumW-1:0]   asum_s3, psum_s3;
	logic signed [dpp_pkg::AerrW:0]    adiff_s3;
	logic signed [dpp_pkg::PosW:0]     pdiff_s3;

	always_ff @(posedge clk) begin
		if (step) begin
			aerr_s3  <= aerr_s2;
			perr_s3  <= perr_s2;
			asum_s3  <= asum_next;
			psum_s3  <= psum_next;
			adiff_s3 <= 19'(aerr_s2) - 19'(prev_angle_err_q);
			pdiff_s3 <= 25'(perr_s2) - 25'(prev_pos_err_q);
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: products; each integral product splits into two
	// 16x24 halves
	// ---------------------------------------------------------------
	logic signed [34:0] pa_s4;
	logic signed [35:0] da_s4;
	logic        [39:0] ia_lo_s4;
	logic signed [40:0] ia_hi_s4;
	logic signed [40:0] pp_s4;
	logic signed [41:0] dp_s4;
	logic        [39:0] ip_lo_s4;
	logic signed [40:0] ip_hi_s4;

	always_ff @(posedge clk) begin
		if (v_s3 && free_s4) begin
			pa_s4    <= $signed({1'b0, angle_p_gain_q}) * aerr_s3;
			da_s4    <= $signed({1'b0, angle_d_gain_q}) * adiff_s3;
			ia_lo_s4 <= angle_i_gain_q * asum_s3[23:0];
			ia_hi_s4 <= $signed({1'b0, angle_i_gain_q}) * $signed(asum_s3[47:24]);
			pp_s4    <= $signed({1'b0, pos_p_gain_q}) * perr_s3;
			dp_s4    <= $signed({1'b0, pos_d_gain_q}) * pdiff_s3;
			ip_lo_s4 <= pos_i_gain_q * psum_s3[23:0];
			ip_hi_s4 <= $signed({1'b0, pos_i_gain_q}) * $signed(psum_s3[47:24]);
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: rebuild the integral products, add P and D
	// ---------------------------------------------------------------
	logic signed [63:0] ia_s5, ip_s5;
	logic signed [36:0] pda_s5;
	logic signed [42:0] pdp_s5;

	always_ff @(posedge clk) begin
		if (v_s4 && free_s5) begin
			ia_s5  <= 64'($signed({ia_hi_s4, 24'd0})) + $signed({24'd0, ia_lo_s4});
			ip_s5  <= 64'($signed({ip_hi_s4, 24'd0})) + $signed({24'd0, ip_lo_s4});
			pda_s5 <= 37'(pa_s4) + 37'(da_s4);
			pdp_s5 <= 43'(pp_s4) + 43'(dp_s4);
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: the two PID terms (bounded inside 64 bits)
	// ---------------------------------------------------------------
	logic signed [63:0] at_s6, pt_s6;

	always_ff @(posedge clk) begin
		if (v_s5 && free_s6) begin
			at_s6 <= ia_s5 + 64'(pda_s5);
			pt_s6 <= ip_s5 + 64'(pdp_s5);
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: difference, clamp to the Q.8 image of 32 bits, floor
	// shift by 8 into the drive register
	// ---------------------------------------------------------------
	logic signed [64:0] diff;
	logic               over, under;
	logic [dpp_pkg::DriveW-1:0] drive_next;

	always_comb begin
		diff  = 65'(at_s6) - 65'(pt_s6);
		over  = !diff[64] && (|diff[63:39]);
		under =  diff[64] && !(&diff[63:39]);
		priority if (over) begin
			drive_next = dpp_pkg::DriveMax;
		end else if (under) begin
			drive_next = dpp_pkg::DriveMin;
		end else begin
			drive_next = diff[39:8];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s6 && free_s7) begin
			drive <= $signed(drive_next);
		end
	end

	// ---------------------------------------------------------------
	// Stage valids; items that find the controller disengaged drop
	// out after the state stage
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (free_s1) v_s1 <= sample_valid;
			if (free_s2) v_s2 <= v_s1;
			if (free_s3) v_s3 <= v_s2 && engage_now;
			if (free_s4) v_s4 <= v_s3;
			if (free_s5) v_s5 <= v_s4;
			if (free_s6) v_s6 <= v_s5;
			if (free_s7) v_s7 <= v_s6;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_engage_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		engaged_q |=> engaged_q)
		else $error("engage latch cleared without reset");

	a_result_needs_engage: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 || drive_valid) |-> engaged_q)
		else $error("result in flight while not engaged");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (drive_valid && drive_stall && v_s1 && v_s6))
		else $error("input stalled with room in the pipeline");

endmodule
